### hw/rtl/slab_slot_allocator_defines.svh
// Assertion macros shared by the slab slot allocator RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef SLAB_SLOT_ALLOCATOR_DEFINES_SVH
`define SLAB_SLOT_ALLOCATOR_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define SLAB_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that forces a consequence in the next cycle.
`define SLAB_CHECK_NEXT(label, ante, cons, msg) \
    `SLAB_CHECK(label, (ante) |=> (cons), msg)

`endif

### hw/rtl/slab_pkg.sv
// Package for the slab slot allocator: sizes, status and state codes, search helpers.
// Depends on nothing; the interface and allocator RTL files import it.
package slab_pkg;

    localparam int NUM_FRAMES      = 8;
    localparam int FRAME_W         = $clog2(NUM_FRAMES);
    localparam int COUNT_W         = $clog2(NUM_FRAMES + 1);
    localparam int SLOTS_PER_FRAME = 15;
    localparam int SLOT_W          = $clog2(SLOTS_PER_FRAME);
    localparam int OBJECT_BYTES    = 256;
    localparam int OBJ_SHIFT       = $clog2(OBJECT_BYTES);
    localparam int AREA_BYTES      = SLOTS_PER_FRAME * OBJECT_BYTES;
    localparam int SIZE_W          = 12;
    localparam int OFF_W           = 12;
    localparam int FA_W            = 4;
    localparam int FA_RESET        = 8;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int STATUS_W        = 3;

    localparam logic REG_FRAMES_ALLOWED = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_BAD_SIZE     = 3'd1,
        ST_NO_FRAME     = 3'd2,
        ST_NOT_SLAB     = 3'd3,
        ST_BAD_RANGE    = 3'd4,
        ST_ALREADY_FREE = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ASCAN,
        S_AOPEN,
        S_FSCAN,
        S_DONE
    } state_t;

    typedef logic [SLOTS_PER_FRAME-1:0] slot_map_t;

    function automatic logic [SLOT_W-1:0] lowest_zero_slot(input slot_map_t map);
        logic [SLOT_W-1:0] res;
        res = '0;
        for (int i = SLOTS_PER_FRAME - 1; i >= 0; i--)
        begin
            if (!map[i])
            begin
                res = SLOT_W'(i);
            end
        end
        return res;
    endfunction

    function automatic logic [FRAME_W-1:0] lowest_clear_frame(
        input logic [NUM_FRAMES-1:0] used
    );
        logic [FRAME_W-1:0] res;
        res = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                res = FRAME_W'(i);
            end
        end
        return res;
    endfunction

endpackage

### hw/rtl/slab_if.sv
// Valid/ready channel interfaces for slab allocator requests and responses.
// Depends on slab_pkg for field widths.
interface slab_in_if
    import slab_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [SIZE_W-1:0]  request_size;
    logic [FRAME_W-1:0] frame_id;
    logic [OFF_W-1:0]   byte_offset;

    modport source(output valid, mode, request_size, frame_id, byte_offset, input ready);
    modport sink(input valid, mode, request_size, frame_id, byte_offset, output ready);
endinterface

interface slab_out_if
    import slab_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  got_frame;
    logic [SLOT_W-1:0]   got_slot;
    logic                opened_frame;
    logic                released_frame;

    modport source(output valid, status, got_frame, got_slot, opened_frame, released_frame,
                   input ready);
    modport sink(input valid, status, got_frame, got_slot, opened_frame, released_frame,
                 output ready);
endinterface

### hw/rtl/slab_slot_allocator.sv
// Channel      | Kind           | Payload
// request      | valid/ready in | mode, request_size, frame_id, byte_offset
// response     | valid/ready out| status, got_frame, got_slot, opened_frame, released_frame
// config (APB) | register port  | frames_allowed at byte address 0
// An allocate scans the open frames from the newest and opens a new frame when all are full;
// a bad size or a plain free goes from the check step straight to the done step,
// and a free that releases its frame scans the recency list (up to 8 entries) to drop it.
// The recency scan reads one entry a cycle through a single compare unit.
// rst_n clears the pool at once; no clearing pass follows reset.
// A finished response waits in the output register while the next request is taken.
module slab_slot_allocator
    import slab_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    slab_in_if.sink            request,
    slab_out_if.source         response
);

    state_t              state_reg, state_next;
    logic [FA_W-1:0]     fa_reg, fa_next;
    logic [COUNT_W-1:0]  k_reg, k_next;
    logic [COUNT_W-1:0]  open_count_reg, open_count_next;
    logic [NUM_FRAMES-1:0] in_use_reg, in_use_next;
    slot_map_t           slot_map_reg [NUM_FRAMES];
    slot_map_t           slot_map_next [NUM_FRAMES];
    logic [FRAME_W-1:0]  rec_reg [NUM_FRAMES];
    logic [FRAME_W-1:0]  rec_next [NUM_FRAMES];
    logic                out_valid_reg, out_valid_next;

    logic                mode_reg, mode_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [FRAME_W-1:0]  fid_reg, fid_next;
    logic [OFF_W-1:0]    off_reg, off_next;

    status_t             res_status_reg, res_status_next;
    logic [FRAME_W-1:0]  res_frame_reg, res_frame_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                res_opened_reg, res_opened_next;
    logic                res_released_reg, res_released_next;

    status_t             out_status_reg, out_status_next;
    logic [FRAME_W-1:0]  out_frame_reg, out_frame_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_opened_reg, out_opened_next;
    logic                out_released_reg, out_released_next;

    logic                cfg_write;
    logic [FRAME_W-1:0]  cur_frame;
    logic [FRAME_W-1:0]  rd_frame;
    slot_map_t           rd_map;
    logic [SLOT_W-1:0]   free_idx;
    slot_map_t           free_bit;
    slot_map_t           cleared_map;
    logic [COUNT_W-1:0]  limit;
    logic [FRAME_W-1:0]  new_frame;
    logic [NUM_FRAMES-1:0] map_nonzero;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_FRAMES_ALLOWED);
    assign prdata    = (paddr[2] == REG_FRAMES_ALLOWED) ? PDATA_W'(fa_reg) : '0;

    assign request.ready           = (state_reg == S_IDLE);
    assign response.valid          = out_valid_reg;
    assign response.status         = out_status_reg;
    assign response.got_frame      = out_frame_reg;
    assign response.got_slot       = out_slot_reg;
    assign response.opened_frame   = out_opened_reg;
    assign response.released_frame = out_released_reg;

    assign cur_frame   = rec_reg[k_reg[FRAME_W-1:0]];
    assign rd_frame    = (state_reg == S_CHECK) ? fid_reg : cur_frame;
    assign rd_map      = slot_map_reg[rd_frame];
    assign free_idx    = off_reg[OBJ_SHIFT +: SLOT_W];
    assign free_bit    = slot_map_t'(1) << free_idx;
    assign cleared_map = rd_map & ~free_bit;
    assign limit       = (fa_reg < FA_W'(NUM_FRAMES)) ? COUNT_W'(fa_reg) : COUNT_W'(NUM_FRAMES);
    assign new_frame   = lowest_clear_frame(in_use_reg);

    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            map_nonzero[i] = |slot_map_reg[i];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        fa_next           = fa_reg;
        k_next            = k_reg;
        open_count_next   = open_count_reg;
        in_use_next       = in_use_reg;
        slot_map_next     = slot_map_reg;
        rec_next          = rec_reg;
        out_valid_next    = out_valid_reg;
        mode_next         = mode_reg;
        size_next         = size_reg;
        fid_next          = fid_reg;
        off_next          = off_reg;
        res_status_next   = res_status_reg;
        res_frame_next    = res_frame_reg;
        res_slot_next     = res_slot_reg;
        res_opened_next   = res_opened_reg;
        res_released_next = res_released_reg;
        out_status_next   = out_status_reg;
        out_frame_next    = out_frame_reg;
        out_slot_next     = out_slot_reg;
        out_opened_next   = out_opened_reg;
        out_released_next = out_released_reg;

        if (cfg_write)
        begin
            fa_next = pwdata[FA_W-1:0];
        end

        if (out_valid_reg && response.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    mode_next  = request.mode;
                    size_next  = request.request_size;
                    fid_next   = request.frame_id;
                    off_next   = request.byte_offset;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_status_next   = ST_OK;
                res_frame_next    = '0;
                res_slot_next     = '0;
                res_opened_next   = 1'b0;
                res_released_next = 1'b0;
                k_next            = '0;
                state_next        = S_DONE;
                if (!mode_reg)
                begin
                    if (size_reg == '0 || size_reg > SIZE_W'(OBJECT_BYTES))
                    begin
                        res_status_next = ST_BAD_SIZE;
                    end
                    else
                    begin
                        state_next = S_ASCAN;
                    end
                end
                else if (!in_use_reg[fid_reg])
                begin
                    res_status_next = ST_NOT_SLAB;
                end
                else if (off_reg >= OFF_W'(AREA_BYTES) || off_reg[OBJ_SHIFT-1:0] != '0)
                begin
                    res_status_next = ST_BAD_RANGE;
                end
                else if ((rd_map & free_bit) == '0)
                begin
                    res_status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    slot_map_next[fid_reg] = cleared_map;
                    if (cleared_map == '0)
                    begin
                        in_use_next[fid_reg] = 1'b0;
                        res_released_next    = 1'b1;
                        state_next           = S_FSCAN;
                    end
                end
            end
            S_ASCAN:
            begin
                if (k_reg == open_count_reg)
                begin
                    state_next = S_AOPEN;
                end
                else if (rd_map != '1)
                begin
                    slot_map_next[cur_frame] = rd_map | (slot_map_t'(1) << lowest_zero_slot(rd_map));
                    res_frame_next = cur_frame;
                    res_slot_next  = lowest_zero_slot(rd_map);
                    state_next     = S_DONE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_AOPEN:
            begin
                state_next = S_DONE;
                if (open_count_reg >= limit || (&in_use_reg))
                begin
                    res_status_next = ST_NO_FRAME;
                end
                else
                begin
                    for (int j = 1; j < NUM_FRAMES; j++)
                    begin
                        rec_next[j] = rec_reg[j-1];
                    end
                    rec_next[0]              = new_frame;
                    open_count_next          = open_count_reg + 1'b1;
                    in_use_next[new_frame]   = 1'b1;
                    slot_map_next[new_frame] = slot_map_t'(1);
                    res_frame_next           = new_frame;
                    res_opened_next          = 1'b1;
                end
            end
            S_FSCAN:
            begin
                if (k_reg == open_count_reg)
                begin
                    state_next = S_DONE;
                end
                else if (cur_frame == fid_reg)
                begin
                    for (int j = 0; j < NUM_FRAMES - 1; j++)
                    begin
                        if (COUNT_W'(j) >= k_reg)
                        begin
                            rec_next[j] = rec_reg[j+1];
                        end
                    end
                    open_count_next = open_count_reg - 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    out_status_next   = res_status_reg;
                    out_frame_next    = res_frame_reg;
                    out_slot_next     = res_slot_reg;
                    out_opened_next   = res_opened_reg;
                    out_released_next = res_released_reg;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fa_reg         <= FA_W'(FA_RESET);
            k_reg          <= '0;
            open_count_reg <= '0;
            in_use_reg     <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                slot_map_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            fa_reg         <= fa_next;
            k_reg          <= k_next;
            open_count_reg <= open_count_next;
            in_use_reg     <= in_use_next;
            out_valid_reg  <= out_valid_next;
            slot_map_reg   <= slot_map_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg          <= rec_next;
        mode_reg         <= mode_next;
        size_reg         <= size_next;
        fid_reg          <= fid_next;
        off_reg          <= off_next;
        res_status_reg   <= res_status_next;
        res_frame_reg    <= res_frame_next;
        res_slot_reg     <= res_slot_next;
        res_opened_reg   <= res_opened_next;
        res_released_reg <= res_released_next;
        out_status_reg   <= out_status_next;
        out_frame_reg    <= out_frame_next;
        out_slot_reg     <= out_slot_next;
        out_opened_reg   <= out_opened_next;
        out_released_reg <= out_released_next;
    end

`include "slab_slot_allocator_defines.svh"

    `SLAB_CHECK(a_count_matches_use, (state_reg == S_IDLE) |-> (COUNT_W'($countones(in_use_reg)) == open_count_reg), "open count differs from frames in use")
    `SLAB_CHECK(a_use_matches_map, in_use_reg == map_nonzero, "frame use flag differs from its slot map")
    `SLAB_CHECK(a_open_bounded, open_count_reg <= COUNT_W'(NUM_FRAMES), "open count exceeds the frame pool")
    `SLAB_CHECK_NEXT(a_accept_to_check, request.valid && request.ready, state_reg == S_CHECK, "accepted transfer did not enter the check step")
    `SLAB_CHECK(a_load_from_done, $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE), "response loaded outside the done step")

endmodule
